[rtl/core/bcru_pkg.sv]
package bcru_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		CMD_JR   = 3'd0,
		CMD_JP   = 3'd1,
		CMD_CALL = 3'd2,
		CMD_RET  = 3'd3,
		CMD_RETI = 3'd4,
		CMD_JPHL = 3'd5,
		CMD_RST  = 3'd6
	} cmd_t;

	typedef enum logic [2:0] {
		COND_ALWAYS = 3'd0,
		COND_NZ     = 3'd1,
		COND_Z      = 3'd2,
		COND_NC     = 3'd3,
		COND_C      = 3'd4
	} cond_t;

	// what the back part does with one instruction
	typedef enum logic [2:0] {
		ACT_FALL = 3'd0,
		ACT_REL  = 3'd1,
		ACT_JUMP = 3'd2,
		ACT_CALL = 3'd3,
		ACT_RET  = 3'd4
	} act_t;

	typedef struct packed {
		logic [2:0]         command;
		logic [2:0]         condition;
		logic               zero_flag;
		logic               carry_flag;
		logic signed [7:0]  offset;
		logic [15:0]        target_address;
		logic [15:0]        hl_value;
		logic [2:0]         vector_index;
		logic [1:0]         instruction_length;
	} in_t;

	typedef struct packed {
		logic [15:0] next_pc;
		logic        taken;
		logic        interrupts_enabled;
		logic        stack_error;
	} out_t;

	typedef struct packed {
		act_t        act;
		logic        ie;
		logic [1:0]  len;
		logic [15:0] dest;
		logic [7:0]  offset;
	} entry_t;

endpackage

[rtl/core/branch_call_return_unit.sv]
// channel   dir   beat                                   handshake
// in        in    bcru_pkg::in_t (instruction + flags)   in_valid / in_ready
// out       out   bcru_pkg::out_t (pc, taken, ie, err)   out_valid / out_ready
//
// one instruction per cycle sustained while out_ready is high
// the back part updates pc and return stack once per instruction;
// the entry under the stack top is prefetched so pops run back to back
// a two-entry queue parts the front from the back, the result register
// parts the back from the consumer
// reset clears pc, stack depth, queue and result valid
module branch_call_return_unit #(
	parameter int unsigned STACK_DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bcru_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output bcru_pkg::out_t out_data
);
	import bcru_pkg::*;

	entry_t front_entry;
	entry_t q_entry;
	logic   q_valid;
	logic   q_ready;

	bcru_front u_front (
		.in_data (in_data),
		.entry   (front_entry)
	);

	bcru_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_data  (front_entry),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_entry)
	);

	bcru_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_valid (q_valid),
		.entry_ready (q_ready),
		.entry       (q_entry),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

	a_fall_not_taken: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && q_ready && q_entry.act == ACT_FALL |=> out_valid && !out_data.taken)
		else $error("fall-through beat reported as taken");

	a_jump_dest: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && q_ready && q_entry.act == ACT_JUMP
		|=> out_data.next_pc == $past(q_entry.dest) && !out_data.stack_error)
		else $error("jump result does not match its destination");

	a_reti_ie: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && q_ready && q_entry.ie |=> out_valid && out_data.interrupts_enabled)
		else $error("return from interrupt lost its enable pulse");

	a_full_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> q_valid)
		else $error("input stalled with an empty queue");

endmodule

[rtl/core/bcru_front.sv]
module bcru_front (
	input  bcru_pkg::in_t    in_data,
	output bcru_pkg::entry_t entry
);
	import bcru_pkg::*;

	logic cond_ok;

	always_comb begin
		unique case (in_data.condition)
			COND_ALWAYS: cond_ok = 1'b1;
			COND_NZ:     cond_ok = !in_data.zero_flag;
			COND_Z:      cond_ok = in_data.zero_flag;
			COND_NC:     cond_ok = !in_data.carry_flag;
			COND_C:      cond_ok = in_data.carry_flag;
			default:     cond_ok = 1'b0;
		endcase
	end

	always_comb begin
		entry.act    = ACT_FALL;
		entry.ie     = 1'b0;
		entry.len    = in_data.instruction_length;
		entry.dest   = in_data.target_address;
		entry.offset = in_data.offset;
		unique case (in_data.command)
			CMD_JR:   entry.act = cond_ok ? ACT_REL : ACT_FALL;
			CMD_JP:   entry.act = cond_ok ? ACT_JUMP : ACT_FALL;
			CMD_CALL: entry.act = cond_ok ? ACT_CALL : ACT_FALL;
			CMD_RET:  entry.act = cond_ok ? ACT_RET : ACT_FALL;
			CMD_RETI: begin
				entry.act = ACT_RET;
				entry.ie  = 1'b1;
			end
			CMD_JPHL: begin
				entry.act  = ACT_JUMP;
				entry.dest = in_data.hl_value;
			end
			CMD_RST: begin
				entry.act  = ACT_CALL;
				entry.dest = {10'd0, in_data.vector_index, 3'd0};
			end
			default:  entry.act = ACT_FALL;
		endcase
	end

endmodule

[rtl/core/bcru_queue.sv]
module bcru_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  bcru_pkg::entry_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output bcru_pkg::entry_t pop_data
);
	import bcru_pkg::*;

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	entry_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != CW'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[rtl/core/bcru_back.sv]
module bcru_back #(
	parameter int unsigned STACK_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             entry_valid,
	output logic             entry_ready,
	input  bcru_pkg::entry_t entry,
	output logic             out_valid,
	input  logic             out_ready,
	output bcru_pkg::out_t   out_data
);
	import bcru_pkg::*;

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

	logic [15:0]   pc_q;
	logic [DW-1:0] depth_q;
	logic [DW-1:0] depth_d;
	logic [15:0]   top_q;
	logic [15:0]   below_q;
	logic [15:0]   stack_mem [STACK_DEPTH];
	logic [DW-1:0] rd_full;
	logic [AW-1:0] rd_addr;
	logic          fire;
	logic          push;
	logic          pop;
	logic [15:0]   fall;
	out_t          res;
	logic          out_valid_q;
	out_t          out_q;

	assign entry_ready = !out_valid_q || out_ready;
	assign fire        = entry_valid && entry_ready;
	assign fall        = pc_q + {14'd0, entry.len};
	assign out_valid   = out_valid_q;
	assign out_data    = out_q;

	always_comb begin
		res.next_pc            = fall;
		res.taken              = 1'b1;
		res.interrupts_enabled = entry.ie;
		res.stack_error        = 1'b0;
		push                   = 1'b0;
		pop                    = 1'b0;
		unique case (entry.act)
			ACT_FALL: res.taken = 1'b0;
			ACT_REL:  res.next_pc = fall + {{8{entry.offset[7]}}, entry.offset};
			ACT_JUMP: res.next_pc = entry.dest;
			ACT_CALL: begin
				res.next_pc = entry.dest;
				// full stack drops the return address
				if (depth_q == DW'(STACK_DEPTH)) begin
					res.stack_error = 1'b1;
				end else begin
					push = 1'b1;
				end
			end
			ACT_RET: begin
				if (depth_q == '0) begin
					res.next_pc     = '0;
					res.stack_error = 1'b1;
				end else begin
					res.next_pc = top_q;
					pop         = 1'b1;
				end
			end
			default:  res.taken = 1'b0;
		endcase
	end

	always_comb begin
		depth_d = depth_q;
		if (fire && push) begin
			depth_d = depth_q + DW'(1);
		end else if (fire && pop) begin
			depth_d = depth_q - DW'(1);
		end
	end

	// prefetch the entry under the new top so back-to-back pops need no bubble
	assign rd_full = depth_d - DW'(2);
	assign rd_addr = rd_full[AW-1:0];

	always_ff @(posedge clk) begin
		if (fire && push) begin
			stack_mem[depth_q[AW-1:0]] <= fall;
		end
		below_q <= stack_mem[rd_addr];
		if (fire && push) begin
			top_q <= fall;
		end else if (fire && pop) begin
			top_q <= below_q;
		end
		if (fire) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= '0;
			depth_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			depth_q <= depth_d;
			if (fire) begin
				pc_q <= res.next_pc;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
